@@ sv/tlbl_pkg.sv @@
// shared types and constants for the lru translation buffer
// no dependencies
`timescale 1ns / 1ps

package tlbl_pkg;

  localparam int unsigned ENTRIES_DEF  = 16;
  localparam int unsigned PG_SHIFT_DEF = 12;
  localparam int unsigned AGE_BITS_DEF = 16;

  localparam int unsigned PAGE_W = 16;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned OFS_W = 12;
  localparam int unsigned PA_W = 28;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned IN_W = 48;
  localparam int unsigned OUT_W = 72;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } req_t;

endpackage

@@ sv/tlbl_cell.sv @@
// one buffer slot: holds valid, page, frame and age, folds its entry into the
// running scan result and hands it on; depends on tlbl_pkg
`timescale 1ns / 1ps

module tlbl_cell #(
  parameter int unsigned ENTRIES  = tlbl_pkg::ENTRIES_DEF,
  parameter int unsigned AGE_BITS = tlbl_pkg::AGE_BITS_DEF,
  parameter int unsigned IDX      = 0,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlbl_pkg::req_t               req_i,
  input  logic                         tok_i,
  input  logic                         hit_i,
  input  logic [tlbl_pkg::FRAME_W-1:0] frame_i,
  input  logic                         free_i,
  input  logic [IW-1:0]                free_idx_i,
  input  logic [AGE_BITS-1:0]          best_age_i,
  input  logic [IW-1:0]                best_idx_i,
  input  logic [tlbl_pkg::PAGE_W-1:0]  best_page_i,
  input  logic [CW-1:0]                nfl_i,
  input  logic                         wr_en_i,
  input  logic [IW-1:0]                wr_idx_i,
  output logic                         tok_o,
  output logic                         hit_o,
  output logic [tlbl_pkg::FRAME_W-1:0] frame_o,
  output logic                         free_o,
  output logic [IW-1:0]                free_idx_o,
  output logic [AGE_BITS-1:0]          best_age_o,
  output logic [IW-1:0]                best_idx_o,
  output logic [tlbl_pkg::PAGE_W-1:0]  best_page_o,
  output logic [CW-1:0]                nfl_o
);

  logic                         valid_q, valid_d;
  logic [tlbl_pkg::PAGE_W-1:0]  page_q, page_d;
  logic [tlbl_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic [AGE_BITS-1:0]          age_q, age_d;
  logic                         match;

  assign match = valid_q && (page_q == req_i.page);

  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    frame_d = frame_q;
    age_d   = age_q;
    if (tok_i) begin
      case (req_i.op)
        tlbl_pkg::OP_LOOKUP: begin
          if (match) begin
            age_d = '0;
          end else if (valid_q && (age_q != '1)) begin
            age_d = age_q + 1'b1;
          end
        end
        tlbl_pkg::OP_FLUSH: begin
          if (match) begin
            valid_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (wr_en_i && (wr_idx_i == IW'(IDX))) begin
      valid_d = 1'b1;
      page_d  = req_i.page;
      frame_d = req_i.frame;
      age_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      page_q  <= '0;
      frame_q <= '0;
      age_q   <= '0;
      tok_o   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      page_q  <= page_d;
      frame_q <= frame_d;
      age_q   <= age_d;
      tok_o   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      hit_o       <= hit_i;
      frame_o     <= frame_i;
      free_o      <= free_i;
      free_idx_o  <= free_idx_i;
      best_age_o  <= best_age_i;
      best_idx_o  <= best_idx_i;
      best_page_o <= best_page_i;
      nfl_o       <= nfl_i;
      if ((req_i.op == tlbl_pkg::OP_LOOKUP) && match) begin
        hit_o   <= 1'b1;
        frame_o <= frame_q;
      end
      if ((req_i.op == tlbl_pkg::OP_FLUSH) && match) begin
        nfl_o <= nfl_i + 1'b1;
      end
      if (!valid_q && !free_i) begin
        free_o     <= 1'b1;
        free_idx_o <= IW'(IDX);
      end
      if (valid_q && ((IDX == 0) || (age_q > best_age_i))) begin
        best_age_o  <= age_q;
        best_idx_o  <= IW'(IDX);
        best_page_o <= page_q;
      end
    end
  end

endmodule

@@ sv/tlb_lru_lookup_insert_flush.sv @@
// top level of the lru translation buffer: request capture, cell chain and result
// register; depends on tlbl_pkg and tlbl_cell
`timescale 1ns / 1ps

// Fully associative translation buffer of ENTRIES slots with age-based LRU
// replacement. Each request (lookup, insert, flush page, no-op) passes once
// down the chain of slot cells, one cell per cycle; a new request is taken
// once the previous one has finished its walk, while its result may still
// wait in the output register. Insert picks the lowest free slot, else
// evicts the oldest valid slot (lowest index on ties).

module tlb_lru_lookup_insert_flush #(
  parameter int unsigned ENTRIES  = tlbl_pkg::ENTRIES_DEF,
  parameter int unsigned PG_SHIFT = tlbl_pkg::PG_SHIFT_DEF,
  parameter int unsigned AGE_BITS = tlbl_pkg::AGE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // opcode[1:0], page_number[17:2], frame_number[33:18], page_offset[45:34]
  input  logic [tlbl_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // hit[0], frame_out[16:1], physical_address[44:17], evicted[45],
  // evicted_page[61:46], flushed[62], occupancy[67:63]
  output logic [tlbl_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [63:0] OFS_MASK64 = (64'd1 << PG_SHIFT) - 64'd1;
  localparam logic [tlbl_pkg::OFS_W-1:0] OFS_MASK = tlbl_pkg::OFS_W'(OFS_MASK64);

  tlbl_pkg::state_e            state_q, state_d;
  tlbl_pkg::req_t              req_q;
  logic [tlbl_pkg::OFS_W-1:0]  ofs_q;
  logic                        start_q;
  logic [CW-1:0]               count_q, count_d;
  logic                        out_valid_q;
  logic [tlbl_pkg::OUT_W-1:0]  out_data_q;
  logic                        accept, finish, wr_en;
  logic [IW-1:0]               wr_idx;

  logic                         tok    [ENTRIES+1];
  logic                         hit    [ENTRIES+1];
  logic [tlbl_pkg::FRAME_W-1:0] frm    [ENTRIES+1];
  logic                         fre    [ENTRIES+1];
  logic [IW-1:0]                fidx   [ENTRIES+1];
  logic [AGE_BITS-1:0]          bage   [ENTRIES+1];
  logic [IW-1:0]                bidx   [ENTRIES+1];
  logic [tlbl_pkg::PAGE_W-1:0]  bpage  [ENTRIES+1];
  logic [CW-1:0]                nfl    [ENTRIES+1];

  logic                         r_hit, r_ev, r_fl;
  logic [tlbl_pkg::FRAME_W-1:0] r_frame;
  logic [tlbl_pkg::PA_W-1:0]    r_pa;
  logic [tlbl_pkg::PAGE_W-1:0]  r_evpage;
  logic [47:0]                  pa_wide;

  assign s_axis_tready_o = (state_q == tlbl_pkg::ST_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;

  assign tok[0]   = start_q;
  assign hit[0]   = 1'b0;
  assign frm[0]   = '0;
  assign fre[0]   = 1'b0;
  assign fidx[0]  = '0;
  assign bage[0]  = '0;
  assign bidx[0]  = '0;
  assign bpage[0] = '0;
  assign nfl[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tlbl_cell #(
      .ENTRIES  (ENTRIES),
      .AGE_BITS (AGE_BITS),
      .IDX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .req_i       (req_q),
      .tok_i       (tok[i]),
      .hit_i       (hit[i]),
      .frame_i     (frm[i]),
      .free_i      (fre[i]),
      .free_idx_i  (fidx[i]),
      .best_age_i  (bage[i]),
      .best_idx_i  (bidx[i]),
      .best_page_i (bpage[i]),
      .nfl_i       (nfl[i]),
      .wr_en_i     (wr_en),
      .wr_idx_i    (wr_idx),
      .tok_o       (tok[i+1]),
      .hit_o       (hit[i+1]),
      .frame_o     (frm[i+1]),
      .free_o      (fre[i+1]),
      .free_idx_o  (fidx[i+1]),
      .best_age_o  (bage[i+1]),
      .best_idx_o  (bidx[i+1]),
      .best_page_o (bpage[i+1]),
      .nfl_o       (nfl[i+1])
    );
  end

  // scan result in the last chain register, waiting for the output slot
  assign finish = (state_q == tlbl_pkg::ST_DONE) && (!out_valid_q || m_axis_tready_i);
  assign wr_en  = finish && (req_q.op == tlbl_pkg::OP_INSERT);
  assign wr_idx = fre[ENTRIES] ? fidx[ENTRIES] : bidx[ENTRIES];

  always_comb begin
    r_hit    = (req_q.op == tlbl_pkg::OP_LOOKUP) && hit[ENTRIES];
    r_frame  = r_hit ? frm[ENTRIES] : '0;
    pa_wide  = ({32'd0, r_frame} << PG_SHIFT) | {36'd0, ofs_q & OFS_MASK};
    r_pa     = r_hit ? tlbl_pkg::PA_W'(pa_wide) : '0;
    r_ev     = (req_q.op == tlbl_pkg::OP_INSERT) && !fre[ENTRIES];
    r_evpage = r_ev ? bpage[ENTRIES] : '0;
    r_fl     = (req_q.op == tlbl_pkg::OP_FLUSH) && (nfl[ENTRIES] != '0);
    count_d  = count_q;
    unique case (req_q.op)
      tlbl_pkg::OP_INSERT: if (!r_ev) count_d = count_q + 1'b1;
      tlbl_pkg::OP_FLUSH:  count_d = count_q - nfl[ENTRIES];
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlbl_pkg::ST_IDLE: if (accept) state_d = tlbl_pkg::ST_SCAN;
      tlbl_pkg::ST_SCAN: if (tok[ENTRIES]) state_d = tlbl_pkg::ST_DONE;
      tlbl_pkg::ST_DONE: if (finish) state_d = tlbl_pkg::ST_IDLE;
      default: state_d = tlbl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlbl_pkg::ST_IDLE;
      start_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.op    <= tlbl_pkg::op_e'(s_axis_tdata_i[1:0]);
      req_q.page  <= s_axis_tdata_i[17:2];
      req_q.frame <= s_axis_tdata_i[33:18];
      ofs_q       <= s_axis_tdata_i[45:34];
    end
    if (finish) begin
      out_data_q <= {4'd0, tlbl_pkg::OCC_W'(count_d), r_fl, r_evpage, r_ev, r_pa,
                     r_frame, r_hit};
    end
  end

endmodule
